/* rtl/core/cal_pkg.sv */
// Shared types and constants of the command-line argument splitter.
`default_nettype none

package cal_pkg;

  // Lexer states; codes above LEX_NORMAL are never entered and act as space.
  typedef enum logic [2:0] {
    LEX_SPACE  = 3'd0,
    LEX_SINGLE = 3'd1,
    LEX_DOUBLE = 3'd2,
    LEX_ESCAPE = 3'd3,
    LEX_NORMAL = 3'd4
  } lex_state_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  // Input operations.
  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOL  = 1'b1
  } op_e;

  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChBlank  = 8'h20;

  localparam int unsigned JobQueueDepth = 4;

  // One classified item: a single result, or the argument-end then line-ok pair.
  typedef struct packed {
    logic  pair;
    kind_e kind;
    logic [7:0] ch;
  } job_t;

endpackage

`default_nettype wire

/* rtl/core/command_line_argument_splitter.sv */
// A beat that yields results enters the job queue when accepted; its first result shows once
// the emitter loads it into the output register. One input beat per cycle unless the queue
// is full; one result beat per popping cycle, two for an end-of-line in an open argument.
// The four-entry job queue and output register set how far the input runs ahead.
// Reset (asynchronous, active low) returns the lexer to the space state and empties
// the queue and the output register; no clearing pass is needed.
`default_nettype none

module command_line_argument_splitter import cal_pkg::*; #(
  parameter int unsigned QueueDepth = JobQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       op_i,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       pop,
  output logic            empty,
  output logic [1:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);

  // The front lexer classifies every accepted beat in the cycle it arrives and
  // writes a job into the queue only when that beat yields results. Bytes that
  // only move the lexer (quotes, escapes, skipped blanks) leave no job.
  logic accept;
  logic job_valid;
  job_t job_in, job_out;
  logic q_empty, q_pop;

  assign accept = push && !full;

  cal_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .op_i        (op_i),
    .char_byte_i (char_byte_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  // The queue decouples the lexer from the output side, so input keeps flowing
  // while a result waits to be popped, until the queue is full.
  cal_job_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job_in),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .full_o  (full),
    .empty_o (q_empty)
  );

  // The emitter holds the oldest job and turns a paired job into the argument
  // end followed by the line-ok status, marking the last beat of each item.
  cal_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

`ifndef SYNTHESIS
  // The first beat of a paired result is always followed by its line-ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && kind_o == KIND_END && !run_last_o) |=>
    (!empty && kind_o == KIND_OK && run_last_o))
    else $error("argument end of a line was not followed by its status");

  // Only argument bytes carry a nonzero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_BYTE) |-> (out_byte_o == 8'h00))
    else $error("non-byte result carries a nonzero byte");

  // Whenever a job waits in the queue, the output register holds a result in the cycle after.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty |=> !empty)
    else $error("queued job did not reach the output");
`endif

endmodule

`default_nettype wire

/* rtl/core/cal_lexer.sv */
// Front part: lexer state machine that classifies each accepted item and turns those that yield results into jobs.
`default_nettype none

module cal_lexer import cal_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic       op_i,
  input  wire logic [7:0] char_byte_i,
  output logic            job_valid_o,
  output job_t            job_o
);

  lex_state_e lex_q, lex_d;
  lex_state_e ret_q, ret_d;

  // Next state.
  always_comb begin
    lex_d = lex_q;
    ret_d = ret_q;
    if (valid_i) begin
      if (op_e'(op_i) == OP_EOL) begin
        lex_d = LEX_SPACE;
        ret_d = LEX_SPACE;
      end else begin
        unique case (lex_q)
          LEX_SINGLE, LEX_DOUBLE: begin
            if ((lex_q == LEX_SINGLE && char_byte_i == ChSquote) ||
                (lex_q == LEX_DOUBLE && char_byte_i == ChDquote)) begin
              lex_d = LEX_NORMAL;
            end else if (char_byte_i == ChBslash) begin
              lex_d = LEX_ESCAPE;
              ret_d = lex_q;
            end
          end
          LEX_ESCAPE: begin
            lex_d = ret_q;
          end
          LEX_NORMAL: begin
            if (char_byte_i == ChBslash) begin
              lex_d = LEX_ESCAPE;
              ret_d = LEX_NORMAL;
            end else if (char_byte_i == ChBlank) begin
              lex_d = LEX_SPACE;
            end
          end
          default: begin
            if (char_byte_i == ChSquote) begin
              lex_d = LEX_SINGLE;
            end else if (char_byte_i == ChDquote) begin
              lex_d = LEX_DOUBLE;
            end else if (char_byte_i == ChBslash) begin
              lex_d = LEX_ESCAPE;
              ret_d = LEX_NORMAL;
            end else if (char_byte_i == ChBlank) begin
              lex_d = LEX_SPACE;
            end else begin
              lex_d = LEX_NORMAL;
            end
          end
        endcase
      end
    end
  end

  // Job outputs.
  always_comb begin
    job_valid_o = 1'b0;
    job_o.pair  = 1'b0;
    job_o.kind  = KIND_BYTE;
    job_o.ch    = char_byte_i;
    if (op_e'(op_i) == OP_EOL) begin
      job_valid_o = valid_i;
      job_o.ch    = 8'h00;
      unique case (lex_q)
        LEX_NORMAL: begin
          job_o.pair = 1'b1;
          job_o.kind = KIND_END;
        end
        LEX_SINGLE, LEX_DOUBLE, LEX_ESCAPE: job_o.kind = KIND_ERR;
        default: job_o.kind = KIND_OK;
      endcase
    end else begin
      unique case (lex_q)
        LEX_SINGLE: job_valid_o = valid_i && char_byte_i != ChSquote &&
                                  char_byte_i != ChBslash;
        LEX_DOUBLE: job_valid_o = valid_i && char_byte_i != ChDquote &&
                                  char_byte_i != ChBslash;
        LEX_ESCAPE: job_valid_o = valid_i;
        LEX_NORMAL: begin
          job_valid_o = valid_i && char_byte_i != ChBslash;
          if (char_byte_i == ChBlank) begin
            job_o.kind = KIND_END;
            job_o.ch   = 8'h00;
          end
        end
        default: job_valid_o = valid_i && char_byte_i != ChSquote &&
                               char_byte_i != ChDquote && char_byte_i != ChBslash &&
                               char_byte_i != ChBlank;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_q <= LEX_SPACE;
      ret_q <= LEX_SPACE;
    end else begin
      lex_q <= lex_d;
      ret_q <= ret_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cal_job_queue.sv */
// Short job queue between the lexer and the result emitter.
`default_nettype none

module cal_job_queue import cal_pkg::*; #(
  parameter int unsigned Depth = JobQueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      data_i,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cal_emitter.sv */
// Back part: output register that expands each job into one or two result beats.
`default_nettype none

module cal_emitter import cal_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       job_valid_i,
  input  job_t            job_i,
  output logic            job_pop_o,
  input  wire logic       pop,
  output logic            empty,
  output logic [1:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);

  job_t job_q;
  logic valid_q, valid_d;
  logic second_q, second_d;
  logic last_beat, load;

  assign last_beat = !job_q.pair || second_q;
  assign load      = !valid_q || (pop && last_beat);
  assign job_pop_o = load && job_valid_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    if (load) begin
      valid_d  = job_valid_i;
      second_d = 1'b0;
    end else if (pop) begin
      second_d = 1'b1;
    end
  end

  assign empty      = !valid_q;
  assign kind_o     = job_q.pair ? (second_q ? KIND_OK : KIND_END) : job_q.kind;
  assign out_byte_o = job_q.ch;
  assign run_last_o = last_beat;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench of the command-line argument splitter.
`default_nettype none

module tb;
  import cal_pkg::*;

  // Stimulus sizes and the stall limit of the watchdog.
  localparam int unsigned LineBeats  = 1150;
  localparam int unsigned CalmAfter  = 1000;
  localparam int unsigned DrainAt    = 500;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 8;

  // One expected result beat, in the order the block must deliver it.
  typedef struct {
    kind_e      kind;
    logic [7:0] ch;
    logic       last;
  } arg_beat_t;

  // The scoreboard keeps its own copy of the lexer and the queue of beats it predicts.
  class arg_scoreboard;
    lex_state_e lex;
    lex_state_e resume;
    arg_beat_t  pending[$];

    function new();
      lex    = LEX_SPACE;
      resume = LEX_SPACE;
    endfunction

    function void add(kind_e k, logic [7:0] c, logic l);
      arg_beat_t b;
      b.kind = k;
      b.ch   = c;
      b.last = l;
      pending.insert(pending.size(), b);
    endfunction

    // Steps the lexer by one accepted input beat and queues what it emits.
    function void note_beat(op_e op, logic [7:0] c);
      if (op == OP_EOL) begin
        case (lex)
          LEX_NORMAL: begin
            add(KIND_END, 8'h00, 1'b0);
            add(KIND_OK, 8'h00, 1'b1);
          end
          LEX_SINGLE, LEX_DOUBLE, LEX_ESCAPE: add(KIND_ERR, 8'h00, 1'b1);
          default: add(KIND_OK, 8'h00, 1'b1);
        endcase
        lex    = LEX_SPACE;
        resume = LEX_SPACE;
        return;
      end
      case (lex)
        LEX_SINGLE: begin
          if (c == ChSquote) lex = LEX_NORMAL;
          else if (c == ChBslash) begin
            lex    = LEX_ESCAPE;
            resume = LEX_SINGLE;
          end else add(KIND_BYTE, c, 1'b1);
        end
        LEX_DOUBLE: begin
          if (c == ChDquote) lex = LEX_NORMAL;
          else if (c == ChBslash) begin
            lex    = LEX_ESCAPE;
            resume = LEX_DOUBLE;
          end else add(KIND_BYTE, c, 1'b1);
        end
        LEX_ESCAPE: begin
          add(KIND_BYTE, c, 1'b1);
          lex = resume;
        end
        LEX_NORMAL: begin
          if (c == ChBslash) begin
            lex    = LEX_ESCAPE;
            resume = LEX_NORMAL;
          end else if (c == ChBlank) begin
            add(KIND_END, 8'h00, 1'b1);
            lex = LEX_SPACE;
          end else add(KIND_BYTE, c, 1'b1);
        end
        default: begin
          // The space state; unused codes behave the same way.
          if (c == ChSquote) lex = LEX_SINGLE;
          else if (c == ChDquote) lex = LEX_DOUBLE;
          else if (c == ChBslash) begin
            lex    = LEX_ESCAPE;
            resume = LEX_NORMAL;
          end else if (c == ChBlank) lex = LEX_SPACE;
          else begin
            add(KIND_BYTE, c, 1'b1);
            lex = LEX_NORMAL;
          end
        end
      endcase
    endfunction

    // Compares one delivered beat with the oldest prediction; returns 0 and a reason on a miss.
    function bit check_beat(logic [1:0] k, logic [7:0] c, logic l, output string why);
      arg_beat_t b;
      why = "";
      if (pending.size() == 0) begin
        why = $sformatf("unexpected result kind=%0d byte=%02h last=%0b", k, c, l);
        return 1'b0;
      end
      b = pending.pop_front();
      if (b.kind != k || b.ch != c || b.last != l) begin
        why = $sformatf({"result kind=%0d byte=%02h last=%0b, ",
                         "expected kind=%0d byte=%02h last=%0b"},
                        k, c, l, b.kind, b.ch, b.last);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       op_i        = 1'b0;
  logic [7:0] char_byte_i = 8'h00;
  logic       pop         = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  arg_scoreboard sb = new();
  int unsigned   errors = 0;
  int unsigned   sent   = 0;
  bit            calm   = 1'b0;

  command_line_argument_splitter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .op_i       (op_i),
    .char_byte_i(char_byte_i),
    .pop        (pop),
    .empty      (empty),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string why);
    $display("mismatch at %0t: %s", $time, why);
    errors++;
  endtask

  // Offers one beat and holds it until the block takes it. Signals are sampled right
  // after the edge, before any nonblocking update of that step lands, so push and full
  // seen here are the values the block saw at the edge. After acceptance the sender
  // sometimes goes quiet for a burst, which lands gaps on every lexer state.
  task automatic send_beat(input op_e op, input logic [7:0] c);
    push        <= 1'b1;
    op_i        <= op;
    char_byte_i <= c;
    do @(posedge clk_i); while (full);
    sb.note_beat(op, c);
    sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    send_beat(OP_CHAR, c);
  endtask

  // The byte that rides along with an end of line is ignored, so it is random.
  task automatic send_eol();
    send_beat(OP_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Any byte that the lexer treats as ordinary text in every state.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChSquote || c == ChDquote || c == ChBslash || c == ChBlank);
    return c;
  endfunction

  // Content of a quoted run: mostly ordinary bytes, some blanks, some of the other quote.
  function automatic logic [7:0] quoted_byte(input logic [7:0] other);
    case ($urandom_range(0, 5))
      0:       return ChBlank;
      1:       return other;
      default: return plain_byte();
    endcase
  endfunction

  // Sends one command line. Most lines are well formed with random words, quoted runs
  // and escapes, so the lexer walks through all its states; a few lines end inside a
  // quote or an escape, and some are plain noise with random bytes and random ends.
  task automatic send_line();
    int unsigned ntok;
    int unsigned n;
    logic [7:0]  q;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) send_eol();
        else send_char(8'($urandom_range(0, 255)));
      end
      return;
    end
    repeat ($urandom_range(0, 2)) send_char(ChBlank);
    ntok = $urandom_range(0, 5);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(1, 6);
          repeat (n) send_char(plain_byte());
          if ($urandom_range(0, 3) == 0) begin
            send_char(ChBslash);
            send_char(8'($urandom_range(0, 255)));
          end
        end
        1, 2: begin
          q = ($urandom_range(0, 1) == 0) ? ChSquote : ChDquote;
          send_char(q);
          n = $urandom_range(0, 5);
          repeat (n) send_char(quoted_byte(q == ChSquote ? ChDquote : ChSquote));
          if ($urandom_range(0, 3) == 0) begin
            send_char(ChBslash);
            send_char(8'($urandom_range(0, 255)));
          end
          send_char(q);
        end
        default: begin
          send_char(ChBslash);
          send_char(8'($urandom_range(0, 255)));
        end
      endcase
      // Tokens that touch with no blank between them join into one argument.
      if (t + 1 < ntok && $urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(1, 2)) send_char(ChBlank);
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0:       send_char(ChSquote);
        1:       send_char(ChDquote);
        default: send_char(ChBslash);
      endcase
    end
    if ($urandom_range(0, 3) == 0) send_char(ChBlank);
    send_eol();
  endtask

  // Receiver: pop stays high except for random stall bursts, of which none start once the run
  // is in its calm tail. A result beat is taken at an edge with pop high and empty low.
  initial begin
    int unsigned stall;
    string       why;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (!sb.check_beat(kind_o, out_byte_o, run_last_o, why)) report_mismatch(why);
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 13);
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  // Watchdog: a stretch in which neither side moves a beat is a hang once it reaches the stall limit.
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle = 0;
      else idle++;
      if (idle >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    bit drained;
    drained = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An end of line straight after reset sits in the space state.
    send_eol();
    // Empty single- and double-quoted arguments must still close an argument.
    send_text("'' \"\"");
    send_eol();
    // Quotes inside a bare word are text; an escape in a word takes the blank literally;
    // the lowest and highest byte values pass through unchanged.
    send_text("a'b\\ ");
    send_char(8'h00);
    send_char(8'hFF);
    send_eol();
    // An escaped quote and a blank inside single quotes, left unterminated.
    send_text("' \\'");
    send_eol();
    // A single quote and an escaped double quote inside double quotes, left unterminated.
    send_text("\"'\\\"");
    send_eol();
    // A line that ends right after a backslash.
    send_char(ChBslash);
    send_eol();

    // Random lines until the beat budget is used; the tail runs without any idling.
    while (sent < LineBeats) begin
      calm = (sent >= CalmAfter);
      if (!drained && sent >= DrainAt) begin
        // Hold the sender off until every predicted result has been delivered.
        drained = 1'b1;
        push <= 1'b0;
        do @(posedge clk_i); while (sb.pending.size() != 0);
      end
      send_line();
    end
    push <= 1'b0;

    // Drain the results, then wait out the tail so the pipeline can show any extras.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", sb.pending.size()));
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
